// ----- rtl/core/lpw_pkg.sv -----
`default_nettype none

package lpw_pkg;

    localparam int NODE_W = 7;
    localparam int TABLE_DEPTH = 128;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_FAULT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] other_node;
        logic              is_root;
    } req_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              status;
    } rsp_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpw_ram.sv -----
`default_nettype none

module lpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lpw_flag_bank.sv -----
`default_nettype none

module lpw_flag_bank #(
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     clr_all,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic                     wr_bit,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                          rd_bit
);

    logic [DEPTH-1:0] bits_reg;
    logic [DEPTH-1:0] bits_next;

    always_comb
    begin
        bits_next = bits_reg;
        if (clr_all)
        begin
            bits_next = '0;
        end
        else if (wr_en)
        begin
            bits_next[wr_addr] = wr_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    assign rd_bit = bits_reg[rd_addr];

endmodule

`default_nettype wire

// ----- rtl/core/lca_parent_table_walk_unit.sv -----
// order: a write takes effect at its transfer; a query walks from its first node to a root,
//   marking each node, then from its second node until it meets a marked node; it answers
//   with a fault, without a walk, when a query node is out of range
// flow: a query holds off new requests until its response is registered, writes do not;
//   each walk step is an evaluation state that issues a parent ram read, then a read state
// reset: root flags and ancestor marks clear at once, the parent table is not cleared
`default_nettype none

module lca_parent_table_walk_unit #(
    parameter int NODES = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire lpw_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output lpw_pkg::rsp_item_t      rsp
);

    localparam int LIVE = (NODES < lpw_pkg::TABLE_DEPTH) ? NODES : lpw_pkg::TABLE_DEPTH;
    localparam int AW = $clog2(LIVE);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam logic [lpw_pkg::NODE_W:0] LIVE_LIM = (lpw_pkg::NODE_W + 1)'(LIVE);
    localparam logic [CNT_W-1:0] STEP_LIM = CNT_W'(NODES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_W1    = 6'b000010,
        ST_W1_RD = 6'b000100,
        ST_W2    = 6'b001000,
        ST_W2_RD = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [lpw_pkg::NODE_W-1:0] cursor_reg, cursor_next;
    logic [lpw_pkg::NODE_W-1:0] second_reg, second_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    lpw_pkg::rsp_item_t         res_reg, res_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    lpw_pkg::rsp_item_t         rsp_reg, rsp_next;

    logic                       req_fire;
    logic                       wr_in_range;
    logic                       root_wr_en;
    logic                       mark_clr;
    logic                       mark_set;
    logic                       root_bit;
    logic                       mark_bit;
    logic                       ram_rd_en;
    logic [lpw_pkg::NODE_W-1:0] parent_rd;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire = req_valid && req_ready;
    assign wr_in_range = ({1'b0, req.node} < LIVE_LIM);
    assign root_wr_en = req_fire && (req.func == lpw_pkg::FUNC_WRITE) && wr_in_range;
    assign mark_clr = req_fire && (req.func == lpw_pkg::FUNC_QUERY);
    assign mark_set = (state_reg == ST_W1) && (cnt_reg < STEP_LIM);
    assign ram_rd_en = (state_reg == ST_W1) || (state_reg == ST_W2);

    lpw_ram #(
        .WIDTH(lpw_pkg::NODE_W),
        .DEPTH(LIVE)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (root_wr_en && !req.is_root),
        .wr_addr (req.node[AW-1:0]),
        .wr_data (req.other_node),
        .rd_en   (ram_rd_en),
        .rd_addr (cursor_reg[AW-1:0]),
        .rd_data (parent_rd)
    );

    lpw_flag_bank #(
        .DEPTH(LIVE)
    ) u_root_flags (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_all (1'b0),
        .wr_en   (root_wr_en),
        .wr_addr (req.node[AW-1:0]),
        .wr_bit  (req.is_root),
        .rd_addr (cursor_reg[AW-1:0]),
        .rd_bit  (root_bit)
    );

    lpw_flag_bank #(
        .DEPTH(LIVE)
    ) u_marks (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_all (mark_clr),
        .wr_en   (mark_set),
        .wr_addr (cursor_reg[AW-1:0]),
        .wr_bit  (1'b1),
        .rd_addr (cursor_reg[AW-1:0]),
        .rd_bit  (mark_bit)
    );

    always_comb
    begin
        state_next = state_reg;
        cursor_next = cursor_reg;
        second_next = second_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.func == lpw_pkg::FUNC_QUERY))
                begin
                    cursor_next = req.node;
                    second_next = req.other_node;
                    cnt_next = '0;
                    if (({1'b0, req.node} < LIVE_LIM) && ({1'b0, req.other_node} < LIVE_LIM))
                    begin
                        state_next = ST_W1;
                    end
                    else
                    begin
                        res_next = '{ancestor: '0, status: lpw_pkg::STATUS_FAULT};
                        state_next = ST_DONE;
                    end
                end
            end
            ST_W1:
            begin
                if (cnt_reg >= STEP_LIM)
                begin
                    res_next = '{ancestor: '0, status: lpw_pkg::STATUS_FAULT};
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (root_bit)
                    begin
                        cursor_next = second_reg;
                        cnt_next = '0;
                        state_next = ST_W2;
                    end
                    else
                    begin
                        state_next = ST_W1_RD;
                    end
                end
            end
            ST_W1_RD, ST_W2_RD:
            begin
                if ({1'b0, parent_rd} >= LIVE_LIM)
                begin
                    res_next = '{ancestor: '0, status: lpw_pkg::STATUS_FAULT};
                    state_next = ST_DONE;
                end
                else
                begin
                    cursor_next = parent_rd;
                    state_next = (state_reg == ST_W1_RD) ? ST_W1 : ST_W2;
                end
            end
            ST_W2:
            begin
                if (cnt_reg >= STEP_LIM)
                begin
                    res_next = '{ancestor: '0, status: lpw_pkg::STATUS_FAULT};
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (mark_bit)
                    begin
                        res_next = '{ancestor: cursor_reg, status: lpw_pkg::STATUS_FOUND};
                        state_next = ST_DONE;
                    end
                    else if (root_bit)
                    begin
                        res_next = '{ancestor: '0, status: lpw_pkg::STATUS_FAULT};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_W2_RD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cursor_reg <= '0;
            cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cursor_reg <= cursor_next;
            cnt_reg <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        second_reg <= second_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lpw_checker.sv -----
`default_nettype none

module lpw_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire lpw_pkg::req_item_t req,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire lpw_pkg::rsp_item_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // fault answers carry a zero ancestor
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == lpw_pkg::STATUS_FAULT) |-> (rsp.ancestor == '0))
        else $error("fault response with nonzero ancestor");

    // a write transfer never produces a response
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.func == lpw_pkg::FUNC_WRITE) && !rsp_valid
        |=> !rsp_valid)
        else $error("response after write transfer");

    // a query keeps the request side closed while it runs
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.func == lpw_pkg::FUNC_QUERY) |=> !req_ready)
        else $error("request accepted during query");

    // responses appear only at the end of a query
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response without a running query");

endmodule

bind lca_parent_table_walk_unit lpw_checker u_lpw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 128;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 4 * NODES + 16;
    localparam int PHASE_ITEMS = 633;

    typedef logic [lpw_pkg::NODE_W-1:0] node_t;

    typedef struct {
        lpw_pkg::req_item_t req;
        bit                 typed;
        lpw_pkg::rsp_item_t rsp;
    } lca_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    lpw_pkg::req_item_t req = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    lpw_pkg::rsp_item_t rsp;

    // shadow of the parent table
    bit    tree_root [lpw_pkg::TABLE_DEPTH];
    node_t tree_parent [lpw_pkg::TABLE_DEPTH];
    bit    tree_parent_known [lpw_pkg::TABLE_DEPTH];

    lpw_pkg::rsp_item_t lca_expected [$];
    lca_row_t           stim_rows [$];
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 send_idle_pct = 0;
    int                 rsp_stall_pct = 0;
    int                 cycle_count = 0;

    lca_parent_table_walk_unit #(.NODES(NODES)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic void table_write(input lpw_pkg::req_item_t it);
        if (it.node < NODES)
        begin
            if (it.is_root)
            begin
                tree_root[it.node] = 1'b1;
            end
            else
            begin
                tree_root[it.node] = 1'b0;
                tree_parent[it.node] = it.other_node;
                tree_parent_known[it.node] = 1'b1;
            end
        end
    endfunction

    // unsafe is set when a walk would read a parent entry never written
    function automatic lpw_pkg::rsp_item_t lca_answer(input node_t a, input node_t b,
                                                      output bit unsafe);
        bit [lpw_pkg::TABLE_DEPTH-1:0] marks;
        node_t                         cur;
        int                            steps;
        lpw_pkg::rsp_item_t            r;
        marks = '0;
        unsafe = 1'b0;
        r.ancestor = '0;
        r.status = lpw_pkg::STATUS_FAULT;
        if (a >= NODES || b >= NODES)
            return r;
        cur = a;
        steps = 0;
        forever
        begin
            if (steps >= NODES)
                return r;
            steps++;
            marks[cur] = 1'b1;
            if (tree_root[cur])
                break;
            if (!tree_parent_known[cur])
            begin
                unsafe = 1'b1;
                return r;
            end
            cur = tree_parent[cur];
            if (cur >= NODES)
                return r;
        end
        cur = b;
        steps = 0;
        forever
        begin
            if (steps >= NODES)
                return r;
            steps++;
            if (marks[cur])
            begin
                r.ancestor = cur;
                r.status = lpw_pkg::STATUS_FOUND;
                return r;
            end
            if (tree_root[cur])
                return r;
            if (!tree_parent_known[cur])
            begin
                unsafe = 1'b1;
                return r;
            end
            cur = tree_parent[cur];
            if (cur >= NODES)
                return r;
        end
    endfunction

    task automatic send_item(input lpw_pkg::req_item_t it, input bit typed,
                             input lpw_pkg::rsp_item_t typed_rsp);
        lpw_pkg::rsp_item_t want;
        bit                 unsafe;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        if (it.func == lpw_pkg::FUNC_WRITE)
        begin
            table_write(it);
        end
        else
        begin
            want = lca_answer(it.node, it.other_node, unsafe);
            if (typed)
                want = typed_rsp;
            lca_expected = {lca_expected, want};
        end
    endtask

    task automatic send_write(input node_t n, input node_t p, input bit root);
        lpw_pkg::req_item_t it;
        it.func = lpw_pkg::FUNC_WRITE;
        it.node = n;
        it.other_node = p;
        if (root)
            it.other_node = node_t'($urandom_range(127));
        it.is_root = root;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_query(input node_t a, input node_t b);
        lpw_pkg::req_item_t it;
        bit                 unsafe;
        void'(lca_answer(a, b, unsafe));
        if (!unsafe)
        begin
            it.func = lpw_pkg::FUNC_QUERY;
            it.node = a;
            it.other_node = b;
            it.is_root = 1'($urandom_range(1));
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        if (lca_expected.size() != 0)
        begin
            req_valid <= 1'b0;
            while (lca_expected.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic tree_episode();
        node_t members [24];
        bit    taken [lpw_pkg::TABLE_DEPTH];
        int    k;
        int    nq;
        int    pick;
        int    r;
        node_t cand;
        k = ($urandom_range(3) == 0) ? $urandom_range(2, 24) : $urandom_range(2, 10);
        for (int i = 0; i < lpw_pkg::TABLE_DEPTH; i++)
            taken[i] = 1'b0;
        for (int i = 0; i < k; i++)
        begin
            cand = node_t'($urandom_range(127));
            while (taken[cand])
                cand = node_t'($urandom_range(127));
            taken[cand] = 1'b1;
            members[i] = cand;
        end
        send_write(members[0], '0, 1'b1);
        for (int i = 1; i < k; i++)
        begin
            pick = ($urandom_range(2) == 0) ? i - 1 : $urandom_range(0, i - 1);
            send_write(members[i], members[pick], 1'b0);
        end
        nq = $urandom_range(2, 10);
        for (int q = 0; q < nq; q++)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                // second root splits the tree
                send_write(members[$urandom_range(1, k - 1)], '0, 1'b1);
            end
            else if (r < 6)
            begin
                // root gets a parent inside its own tree: cycle
                send_write(members[0], members[$urandom_range(1, k - 1)], 1'b0);
            end
            else if (r < 9)
            begin
                pick = $urandom_range(1, k - 1);
                send_write(members[pick], members[$urandom_range(0, pick - 1)], 1'b0);
            end
            else if (r < 15)
            begin
                send_query(node_t'($urandom_range(127)), node_t'($urandom_range(127)));
            end
            else
            begin
                send_query(members[$urandom_range(0, k - 1)],
                           members[$urandom_range(0, k - 1)]);
            end
        end
        if ($urandom_range(19) == 0)
            drain_results();
    endtask

    // every node on one chain, walks of full length
    task automatic chain_episode();
        int perm [lpw_pkg::TABLE_DEPTH];
        int j;
        int tmp;
        for (int i = 0; i < lpw_pkg::TABLE_DEPTH; i++)
            perm[i] = i;
        for (int i = lpw_pkg::TABLE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        send_write(node_t'(perm[lpw_pkg::TABLE_DEPTH - 1]), '0, 1'b1);
        for (int i = lpw_pkg::TABLE_DEPTH - 2; i >= 0; i--)
            send_write(node_t'(perm[i]), node_t'(perm[i + 1]), 1'b0);
        send_query(node_t'(perm[0]), node_t'(perm[0]));
        send_query(node_t'(perm[0]), node_t'(perm[lpw_pkg::TABLE_DEPTH - 1]));
        send_query(node_t'(perm[lpw_pkg::TABLE_DEPTH - 1]), node_t'(perm[0]));
        send_query(node_t'(perm[$urandom_range(127)]), node_t'(perm[$urandom_range(127)]));
        if ($urandom_range(1) == 0)
        begin
            send_write(node_t'(perm[lpw_pkg::TABLE_DEPTH - 1]), node_t'(perm[0]), 1'b0);
            send_query(node_t'(perm[0]), node_t'(perm[$urandom_range(127)]));
            send_write(node_t'(perm[lpw_pkg::TABLE_DEPTH - 1]), '0, 1'b1);
        end
    endtask

    function automatic void add_row(input logic func, input int n, input int o,
                                    input logic root, input bit typed, input int anc,
                                    input logic st);
        lca_row_t row;
        row.req.func = func;
        row.req.node = node_t'(n);
        row.req.other_node = node_t'(o);
        row.req.is_root = root;
        row.typed = typed;
        row.rsp.ancestor = node_t'(anc);
        row.rsp.status = st;
        stim_rows = {stim_rows, row};
    endfunction

    always @(posedge clk)
    begin
        lpw_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (lca_expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: ancestor %0d status %0d",
                                          rsp.ancestor, rsp.status));
            end
            else
            begin
                want = lca_expected.pop_front();
                if (rsp.ancestor !== want.ancestor)
                    report_mismatch($sformatf("ancestor %0d, wanted %0d",
                                              rsp.ancestor, want.ancestor));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp.status, want.status));
            end
        end
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    initial
    begin
        int phase_end;
        for (int i = 0; i < lpw_pkg::TABLE_DEPTH; i++)
        begin
            tree_root[i] = 1'b0;
            tree_parent[i] = '0;
            tree_parent_known[i] = 1'b0;
        end
        add_row(lpw_pkg::FUNC_WRITE, 0, 'h7F, 1'b1, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 0, 0, 1'b0, 1'b1, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 127, 0, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 1, 127, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 127, 1, 1'b0, 1'b1, 127, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 1, 127, 1'b1, 1'b1, 127, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 127, 'h7F, 1'b1, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 1, 0, 1'b0, 1'b1, 0, lpw_pkg::STATUS_FAULT);
        add_row(lpw_pkg::FUNC_WRITE, 127, 0, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 1, 0, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 0, 1, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 1, 1, 1'b0, 1'b1, 0, lpw_pkg::STATUS_FAULT);
        add_row(lpw_pkg::FUNC_WRITE, 0, 0, 1'b1, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 0, 1, 1'b1, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 2, 3, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_WRITE, 3, 2, 1'b0, 1'b0, 0, lpw_pkg::STATUS_FOUND);
        add_row(lpw_pkg::FUNC_QUERY, 0, 2, 1'b0, 1'b1, 0, lpw_pkg::STATUS_FAULT);
        add_row(lpw_pkg::FUNC_QUERY, 2, 0, 1'b0, 1'b1, 0, lpw_pkg::STATUS_FAULT);
        add_row(lpw_pkg::FUNC_QUERY, 127, 127, 1'b1, 1'b0, 0, lpw_pkg::STATUS_FOUND);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        rsp_stall_pct = 63;
        foreach (stim_rows[i])
            send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
        drain_results();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 33;
                    rsp_stall_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    rsp_stall_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 3)
                    chain_episode();
                else
                    tree_episode();
            end
            drain_results();
        end

        req_valid <= 1'b0;
        while (lca_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/lpw_pkg.sv
rtl/core/lpw_ram.sv
rtl/core/lpw_flag_bank.sv
rtl/core/lca_parent_table_walk_unit.sv
rtl/core/lpw_checker.sv
sim/tb_top.sv
